// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CHK_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ffcs_pkg.sv =====
// ---------------------------------------------------------------------------
// ffcs_pkg
// Types, register indexes and constants for the flex fuel cold start heater.
// ---------------------------------------------------------------------------
`default_nettype none

package ffcs_pkg;

  // Configuration port
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;

  // Fixed constants of the control law
  localparam int PCT_MAX   = 100;
  localparam int MS_PER_S  = 1000;
  localparam int SAT_MAX   = 255;

  // x / 100 as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
  localparam int DIV100_MUL    = 41944;
  localparam int DIV100_SHIFT  = 22;
  // x / 1000 as (x * DIV1000_MUL) >> DIV1000_SHIFT, exact for x < 493447
  localparam int DIV1000_MUL   = 268436;
  localparam int DIV1000_SHIFT = 28;
  // remaining milliseconds at which the seconds count saturates
  localparam int SEC_SAT_MS    = (SAT_MAX + 1) * MS_PER_S;

  typedef logic signed [8:0]  temp_t;
  typedef logic signed [7:0]  mtemp_t;
  typedef logic        [7:0]  pct_t;
  typedef logic        [15:0] rpm_t;
  typedef logic        [15:0] ms_t;
  typedef logic        [21:0] budget_ms_t;
  typedef logic signed [16:0] prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_E0_MIN   = 3'd0,
    REG_E100_MIN = 3'd1,
    REG_WARMUP   = 3'd2,
    REG_RUN_RPM  = 3'd3,
    REG_BUDGET   = 3'd4,
    REG_HEATER   = 3'd5,
    REG_ENABLE   = 3'd6
  } reg_idx_t;

  // How the output stage produces the remaining seconds
  typedef enum logic [1:0] {
    SEC_KEEP,
    SEC_ZERO,
    SEC_CALC
  } sec_mode_t;

  typedef struct packed {
    mtemp_t      e0_min_temp;
    mtemp_t      e100_min_temp;
    temp_t       warmup_temp;
    logic [13:0] running_rpm;
    budget_ms_t  budget_ms;
    logic        heater_present;
    logic        block_enable;
  } cfg_t;

  // Front stage result
  typedef struct packed {
    prod_t  prod;
    logic   running;
    logic   cold;
    temp_t  coolant_temp;
    ms_t    elapsed_ms;
  } front_t;

  // Control stage result, also the held controller state
  typedef struct packed {
    logic [7:0] needed_temp;
    logic       coolant_cold;
    logic       too_cold;
    logic       heater_on;
    logic       start_ready;
    sec_mode_t  sec_mode;
    budget_ms_t rem;
  } ctrl_res_t;

  typedef struct packed {
    logic [7:0] needed_temp;
    logic       coolant_cold;
    logic       too_cold_to_start;
    logic       heater_on;
    logic [7:0] heater_seconds_left;
    logic       start_ready;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/ffcs_if.sv =====
// ---------------------------------------------------------------------------
// ffcs_if
// Valid/ready channels for sensor ticks and heater control results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffcs_in_if import ffcs_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t coolant_temp;
  pct_t  ethanol_pct;
  rpm_t  engine_rpm;
  ms_t   elapsed_ms;

  modport source (output valid, output coolant_temp, output ethanol_pct,
                  output engine_rpm, output elapsed_ms, input ready);
  modport sink   (input valid, input coolant_temp, input ethanol_pct,
                  input engine_rpm, input elapsed_ms, output ready);
endinterface

interface ffcs_out_if import ffcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] needed_temp;
  logic       coolant_cold;
  logic       too_cold_to_start;
  logic       heater_on;
  logic [7:0] heater_seconds_left;
  logic       start_ready;

  modport source (output valid, output needed_temp, output coolant_cold,
                  output too_cold_to_start, output heater_on,
                  output heater_seconds_left, output start_ready, input ready);
  modport sink   (input valid, input needed_temp, input coolant_cold,
                  input too_cold_to_start, input heater_on,
                  input heater_seconds_left, input start_ready, output ready);
endinterface

`default_nettype wire

// ===== rtl/flex_fuel_cold_start_heater.sv =====
// ---------------------------------------------------------------------------
// flex_fuel_cold_start_heater
// Cold start preheater controller for flex fuel engines.
//
// Usage:
//   in_ch carries one sensor tick per request (coolant temperature, ethanol
//   percent, rpm, milliseconds since the last tick); out_ch returns exactly
//   one result per tick, in order. Both are valid/ready channels.
//   The cfg_we/cfg_index/cfg_data port writes the seven setup registers;
//   write them only while no tick is in flight.
//   A tick passes the input, product, control and output register stages
//   in turn, each advancing on its own. Throughput: one tick per cycle
//   while out_ch is not stalled. When out_ch stalls, the stages ahead keep
//   filling; in_ch.ready drops only when all four stages hold a tick.
//   Reset (synchronous, rst high) empties the pipeline, clears the heater
//   time and held outputs to zero and loads the default setup values.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flex_fuel_cold_start_heater import ffcs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ffcs_in_if.sink                   in_ch,
  ffcs_out_if.source                out_ch
);

  cfg_t      cfg;
  front_t    stage_b;
  ctrl_res_t stage_c;
  out_t      res;

  logic a_valid, b_valid, c_valid, d_valid;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic load_a, load_b, load_c, load_d;

  // Per-stage flow control
  always_comb begin
    rdy_d  = !d_valid || out_ch.ready;
    rdy_c  = !c_valid || rdy_d;
    rdy_b  = !b_valid || rdy_c;
    rdy_a  = !a_valid || rdy_b;
    load_a = in_ch.valid && rdy_a;
    load_b = a_valid && rdy_b;
    load_c = b_valid && rdy_c;
    load_d = c_valid && rdy_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (rdy_a) a_valid <= in_ch.valid;
      if (rdy_b) b_valid <= a_valid;
      if (rdy_c) c_valid <= b_valid;
      if (rdy_d) d_valid <= c_valid;
    end
  end

  ffcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ffcs_front u_front (
    .clk          (clk),
    .load_a       (load_a),
    .load_b       (load_b),
    .coolant_temp (in_ch.coolant_temp),
    .ethanol_pct  (in_ch.ethanol_pct),
    .engine_rpm   (in_ch.engine_rpm),
    .elapsed_ms   (in_ch.elapsed_ms),
    .cfg          (cfg),
    .stage_b      (stage_b)
  );

  ffcs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .load_c  (load_c),
    .cfg     (cfg),
    .stage_b (stage_b),
    .stage_c (stage_c)
  );

  ffcs_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load_d  (load_d),
    .stage_c (stage_c),
    .res     (res)
  );

  // Channel outputs
  assign in_ch.ready                = rdy_a;
  assign out_ch.valid               = d_valid;
  assign out_ch.needed_temp         = res.needed_temp;
  assign out_ch.coolant_cold        = res.coolant_cold;
  assign out_ch.too_cold_to_start   = res.too_cold_to_start;
  assign out_ch.heater_on           = res.heater_on;
  assign out_ch.heater_seconds_left = res.heater_seconds_left;
  assign out_ch.start_ready         = res.start_ready;

  // Checks
  `CHK_ALWAYS(a_heater_blocks_start, !(res.heater_on && res.start_ready), "heater on with start ready")
  `CHK_IMPL(a_seconds_need_heater, res.heater_seconds_left != 8'd0, res.heater_on, "seconds left without heater")
  `CHK_NEXT(a_result_held, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(res), "result moved")
  `CHK_IMPL(a_backpressure_only, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output stall")

endmodule

`default_nettype wire

// ===== rtl/ffcs_cfg.sv =====
// ---------------------------------------------------------------------------
// ffcs_cfg
// Configuration registers; the heater budget is kept in milliseconds.
// ---------------------------------------------------------------------------
`default_nettype none

module ffcs_cfg import ffcs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.e0_min_temp    <= 8'sd10;
      cfg.e100_min_temp  <= 8'sd20;
      cfg.warmup_temp    <= 9'sd60;
      cfg.running_rpm    <= 14'd400;
      cfg.budget_ms      <= budget_ms_t'(120 * MS_PER_S);
      cfg.heater_present <= 1'b1;
      cfg.block_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_E0_MIN:   cfg.e0_min_temp    <= cfg_data[7:0];
        REG_E100_MIN: cfg.e100_min_temp  <= cfg_data[7:0];
        REG_WARMUP:   cfg.warmup_temp    <= cfg_data[8:0];
        REG_RUN_RPM:  cfg.running_rpm    <= cfg_data[13:0];
        REG_BUDGET:   cfg.budget_ms      <= {10'b0, cfg_data[11:0]} *
                                            budget_ms_t'(MS_PER_S);
        REG_HEATER:   cfg.heater_present <= cfg_data[0];
        REG_ENABLE:   cfg.block_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffcs_front.sv =====
// ---------------------------------------------------------------------------
// ffcs_front
// Input register, ethanol clamp, interpolation product and threshold tests.
// ---------------------------------------------------------------------------
`default_nettype none

module ffcs_front import ffcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  load_a,
  input  wire logic  load_b,
  input  wire temp_t coolant_temp,
  input  wire pct_t  ethanol_pct,
  input  wire rpm_t  engine_rpm,
  input  wire ms_t   elapsed_ms,
  input  wire cfg_t  cfg,
  output front_t     stage_b
);

  temp_t a_clt;
  pct_t  a_pct;
  rpm_t  a_rpm;
  ms_t   a_dt;

  logic [6:0]        pct_clamped;
  logic signed [8:0] diff;
  front_t            stage_b_next;

  // Input register
  always_ff @(posedge clk) begin
    if (load_a) begin
      a_clt <= coolant_temp;
      a_pct <= ethanol_pct;
      a_rpm <= engine_rpm;
      a_dt  <= elapsed_ms;
    end
  end

  // (e100 - e0) * pct, pct clamped to 100
  always_comb begin
    pct_clamped = (a_pct > 8'(PCT_MAX)) ? 7'(PCT_MAX) : a_pct[6:0];
    diff = {cfg.e100_min_temp[7], cfg.e100_min_temp} -
           {cfg.e0_min_temp[7], cfg.e0_min_temp};
    stage_b_next.prod         = prod_t'(diff) * prod_t'($signed({1'b0, pct_clamped}));
    stage_b_next.running      = a_rpm >= {2'b00, cfg.running_rpm};
    stage_b_next.cold         = a_clt < cfg.warmup_temp;
    stage_b_next.coolant_temp = a_clt;
    stage_b_next.elapsed_ms   = a_dt;
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      stage_b <= stage_b_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// ffcs_ctrl
// Needed temperature, start decision and heater time accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module ffcs_ctrl import ffcs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load_c,
  input  wire cfg_t   cfg,
  input  wire front_t stage_b,
  output ctrl_res_t   stage_c
);

  // stage_c doubles as the held state of the last processed tick
  budget_ms_t heater_time_ms;
  budget_ms_t heater_time_ms_next;
  ctrl_res_t  stage_c_next;

  logic               neg;
  logic [15:0]        mag;
  logic [31:0]        quot_full;
  logic [8:0]         quot;
  logic signed [10:0] quot_s;
  logic signed [10:0] needed;
  logic signed [10:0] clt_ext;
  logic               too_cold;
  logic               time_lt;
  logic [22:0]        time_sum;
  logic               time_done;
  budget_ms_t         rem;

  // Signed divide by 100 toward zero: magnitude times reciprocal
  always_comb begin
    neg       = stage_b.prod[16];
    mag       = neg ? 16'(-stage_b.prod) : 16'(stage_b.prod);
    quot_full = 32'(mag) * 32'(DIV100_MUL);
    quot      = quot_full[DIV100_SHIFT +: 9];
    quot_s    = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    needed    = $signed({{3{cfg.e0_min_temp[7]}}, cfg.e0_min_temp}) + quot_s;
    clt_ext   = $signed({{2{stage_b.coolant_temp[8]}}, stage_b.coolant_temp});
    too_cold  = !stage_b.running && (clt_ext < needed);
  end

  // Heater time arithmetic, independent of the temperature path
  always_comb begin
    time_lt   = heater_time_ms < cfg.budget_ms;
    time_sum  = {1'b0, heater_time_ms} + 23'(stage_b.elapsed_ms);
    time_done = time_sum >= {1'b0, cfg.budget_ms};
    rem       = cfg.budget_ms - time_sum[21:0];
  end

  // Next state
  always_comb begin
    stage_c_next          = stage_c;
    stage_c_next.sec_mode = SEC_KEEP;
    heater_time_ms_next   = heater_time_ms;
    if (cfg.block_enable) begin
      if (needed < 0) begin
        stage_c_next.needed_temp = 8'd0;
      end else if (needed > 11'(SAT_MAX)) begin
        stage_c_next.needed_temp = 8'(SAT_MAX);
      end else begin
        stage_c_next.needed_temp = needed[7:0];
      end
      stage_c_next.coolant_cold = stage_b.cold;
      stage_c_next.too_cold     = too_cold;
      if (!too_cold) begin
        // running or warm enough
        stage_c_next.heater_on   = 1'b0;
        stage_c_next.start_ready = 1'b1;
        stage_c_next.sec_mode    = SEC_ZERO;
        heater_time_ms_next      = '0;
      end else if (cfg.heater_present) begin
        if (time_lt) begin
          stage_c_next.heater_on   = 1'b1;
          stage_c_next.start_ready = 1'b0;
          stage_c_next.sec_mode    = time_done ? SEC_ZERO : SEC_CALC;
          stage_c_next.rem         = rem;
          heater_time_ms_next      = time_sum[21:0];
        end else begin
          // budget spent
          stage_c_next.heater_on   = 1'b0;
          stage_c_next.start_ready = 1'b1;
          stage_c_next.sec_mode    = SEC_ZERO;
        end
      end else begin
        // warning only
        stage_c_next.start_ready = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_c        <= '0;
      heater_time_ms <= '0;
    end else if (load_c) begin
      stage_c        <= stage_c_next;
      heater_time_ms <= heater_time_ms_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffcs_out.sv =====
// ---------------------------------------------------------------------------
// ffcs_out
// Remaining seconds (divide by 1000, saturate) and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ffcs_out import ffcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load_d,
  input  wire ctrl_res_t stage_c,
  output out_t           res
);

  logic [36:0] sec_full;
  logic [7:0]  sec_calc;
  out_t        res_next;

  // Seconds left; saturates once 256 s or more remain
  always_comb begin
    sec_full = 37'(stage_c.rem[17:0]) * 37'(DIV1000_MUL);
    sec_calc = (stage_c.rem >= budget_ms_t'(SEC_SAT_MS)) ? 8'(SAT_MAX)
                                                        : sec_full[DIV1000_SHIFT +: 8];
  end

  always_comb begin
    res_next.needed_temp       = stage_c.needed_temp;
    res_next.coolant_cold      = stage_c.coolant_cold;
    res_next.too_cold_to_start = stage_c.too_cold;
    res_next.heater_on         = stage_c.heater_on;
    res_next.start_ready       = stage_c.start_ready;
    case (stage_c.sec_mode)
      SEC_ZERO: res_next.heater_seconds_left = 8'd0;
      SEC_CALC: res_next.heater_seconds_left = sec_calc;
      default:  res_next.heater_seconds_left = res.heater_seconds_left;
    endcase
  end

  // Output register; seconds field also holds state across ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (load_d) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/flex_fuel_cold_start_heater_test.sv =====
// ---------------------------------------------------------------------------
// flex_fuel_cold_start_heater_test
// Self-checking bench for the flex fuel cold start heater. Sensor ticks go
// in through a queue-fed driver and results are checked by a monitor against
// an in-bench predictor of the heater control law. Directed ticks cover the
// interpolation, budget edges, no-heater and disabled cases. Random rounds
// then run cold start sequences and noise under varied setups and idling.
// ---------------------------------------------------------------------------
module flex_fuel_cold_start_heater_test import ffcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    temp_t coolant_temp;
    pct_t  ethanol_pct;
    rpm_t  engine_rpm;
    ms_t   elapsed_ms;
  } tick_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ffcs_in_if  in_ch();
  ffcs_out_if out_ch();

  flex_fuel_cold_start_heater uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // Setup registers as the block should hold them
  mtemp_t      set_e0;
  mtemp_t      set_e100;
  temp_t       set_warmup;
  logic [13:0] set_run_rpm;
  logic [11:0] set_budget_s;
  logic        set_htr_fit;
  logic        set_enable;

  // Controller state as the block should hold it
  int unsigned heat_ms;
  logic        heat_on;
  logic [7:0]  secs_hold;
  logic        ready_hold;
  logic [7:0]  needed_hold;
  logic        cold_hold;
  logic        too_cold_hold;

  tick_t pending_ticks[$];
  out_t  expected_results[$];

  bit idle_in;
  bit idle_out;
  int in_gap;
  int out_gap;
  tick_t drv_tick;

  int n_errors;
  int n_accepted;
  int n_results;
  int n_heating;
  int n_too_cold;
  int n_setups;

  // One tick of the heater control law; updates the predicted state
  function automatic out_t predict_heater(tick_t t);
    temp_t       clt;
    int          pct_i;
    int          needed;
    int unsigned budget_ms;
    int unsigned left;
    logic        running;
    logic        too_cold;
    out_t        r;
    if (set_enable) begin
      clt = t.coolant_temp;
      pct_i = (t.ethanol_pct > 8'd100) ? 100 : int'(t.ethanol_pct);
      running = t.engine_rpm >= set_run_rpm;
      // signed division, truncates toward zero
      needed = int'(set_e0) + ((int'(set_e100) - int'(set_e0)) * pct_i) / 100;
      needed_hold = (needed < 0) ? 8'd0 : (needed > 255) ? 8'd255 : needed[7:0];
      cold_hold = int'(clt) < int'(set_warmup);
      too_cold = !running && (int'(clt) < needed);
      too_cold_hold = too_cold;
      if (!too_cold) begin
        heat_on = 1'b0;
        heat_ms = 0;
        secs_hold = 8'd0;
        ready_hold = 1'b1;
      end else if (set_htr_fit) begin
        budget_ms = int'(set_budget_s) * 1000;
        if (heat_ms < budget_ms) begin
          heat_on = 1'b1;
          heat_ms += t.elapsed_ms;
          // last heater tick lands on zero, never wraps
          left = (heat_ms >= budget_ms) ? 0 : (budget_ms - heat_ms) / 1000;
          secs_hold = (left > 255) ? 8'd255 : left[7:0];
          ready_hold = 1'b0;
        end else begin
          // budget spent: let it crank anyway
          heat_on = 1'b0;
          secs_hold = 8'd0;
          ready_hold = 1'b1;
        end
      end else begin
        ready_hold = 1'b0;
      end
    end
    r.needed_temp = needed_hold;
    r.coolant_cold = cold_hold;
    r.too_cold_to_start = too_cold_hold;
    r.heater_on = heat_on;
    r.heater_seconds_left = secs_hold;
    r.start_ready = ready_hold;
    return r;
  endfunction

  function automatic string fmt_result(out_t r);
    return $sformatf("needed %0d cold %0b too_cold %0b heater %0b secs %0d ready %0b",
                     r.needed_temp, r.coolant_cold, r.too_cold_to_start, r.heater_on,
                     r.heater_seconds_left, r.start_ready);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(99, 0);
    if (!on || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sensor tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_heater(drv_tick));
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          drv_tick = pending_ticks.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.coolant_temp <= drv_tick.coolant_temp;
          in_ch.ethanol_pct <= drv_tick.ethanol_pct;
          in_ch.engine_rpm <= drv_tick.engine_rpm;
          in_ch.elapsed_ms <= drv_tick.elapsed_ms;
          in_gap = pick_gap(idle_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.needed_temp = out_ch.needed_temp;
        got.coolant_cold = out_ch.coolant_cold;
        got.too_cold_to_start = out_ch.too_cold_to_start;
        got.heater_on = out_ch.heater_on;
        got.heater_seconds_left = out_ch.heater_seconds_left;
        got.start_ready = out_ch.start_ready;
        n_results++;
        if (got.heater_on === 1'b1) n_heating++;
        if (got.too_cold_to_start === 1'b1) n_too_cold++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result: %s", fmt_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
        out_gap = pick_gap(idle_out);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One register write, ends at a falling edge so ticks can be queued safely
  task automatic write_setup(reg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      REG_E0_MIN:   set_e0 = value[7:0];
      REG_E100_MIN: set_e100 = value[7:0];
      REG_WARMUP:   set_warmup = value[8:0];
      REG_RUN_RPM:  set_run_rpm = value[13:0];
      REG_BUDGET:   set_budget_s = value[11:0];
      REG_HEATER:   set_htr_fit = value[0];
      REG_ENABLE:   set_enable = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setup(int e0, int e100, int warm, int rpm, int bud, int htr,
                             int en);
    write_setup(REG_E0_MIN, e0);
    write_setup(REG_E100_MIN, e100);
    write_setup(REG_WARMUP, warm);
    write_setup(REG_RUN_RPM, rpm);
    write_setup(REG_BUDGET, bud);
    write_setup(REG_HEATER, htr);
    write_setup(REG_ENABLE, en);
    n_setups++;
  endtask

  task automatic random_setup();
    int r_rpm;
    int r_bud;
    int rpm;
    int bud;
    r_rpm = $urandom_range(9, 0);
    r_bud = $urandom_range(9, 0);
    rpm = (r_rpm == 0) ? 0 : (r_rpm == 1) ? 16000 : $urandom_range(1500, 200);
    bud = (r_bud == 0) ? 0 : (r_bud == 1) ? 3600 : $urandom_range(40, 1);
    apply_setup($urandom_range(140, 0) - 40, $urandom_range(140, 0) - 40,
                $urandom_range(190, 0) - 40, rpm, bud,
                ($urandom_range(7, 0) != 0), ($urandom_range(9, 0) != 0));
  endtask

  task automatic queue_tick(int clt, int pct, int rpm, int dt);
    tick_t t;
    t.coolant_temp = clt[8:0];
    t.ethanol_pct = pct[7:0];
    t.engine_rpm = rpm[15:0];
    t.elapsed_ms = dt[15:0];
    pending_ticks.push_back(t);
  endtask

  // Key-on while cold: cranking speed, slowly warming, then it fires or warms up
  task automatic queue_cold_start();
    int n;
    int k;
    int clt;
    int pct;
    int rpm_lim;
    int dt_max;
    n = $urandom_range(20, 3);
    pct = $urandom_range(255, 0);
    clt = $urandom_range(60, 0) - 40;
    rpm_lim = (set_run_rpm == 0) ? 0 : int'(set_run_rpm) - 1;
    dt_max = int'(set_budget_s) * 200;
    if (dt_max < 1000) dt_max = 1000;
    if (dt_max > 65535) dt_max = 65535;
    for (k = 0; k < n; k++) begin
      queue_tick(clt, pct, $urandom_range(rpm_lim, 0), $urandom_range(dt_max, 0));
      clt = clt + int'($urandom_range(1, 0));
    end
    if ($urandom_range(1, 0))
      queue_tick(clt, pct, $urandom_range(65535, int'(set_run_rpm)), $urandom_range(dt_max, 0));
    else
      queue_tick($urandom_range(150, 100), pct, 0, $urandom_range(dt_max, 0));
  endtask

  task automatic queue_random(int upto);
    while (pending_ticks.size() < upto) begin
      if ($urandom_range(4, 0) == 0)
        queue_tick($urandom, $urandom, $urandom, $urandom);
      else
        queue_cold_start();
    end
  endtask

  // Sender holds off until every outstanding result is back
  task automatic drain_results();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int round;
    int n_round;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.coolant_temp = '0;
    in_ch.ethanol_pct = '0;
    in_ch.engine_rpm = '0;
    in_ch.elapsed_ms = '0;
    out_ch.ready = 1'b0;
    idle_in = 1'b0;
    idle_out = 1'b0;
    set_e0 = 8'sd10;
    set_e100 = 8'sd20;
    set_warmup = 9'sd60;
    set_run_rpm = 14'd400;
    set_budget_s = 12'd120;
    set_htr_fit = 1'b1;
    set_enable = 1'b1;
    heat_ms = 0;
    heat_on = 1'b0;
    secs_hold = '0;
    ready_hold = 1'b0;
    needed_hold = '0;
    cold_hold = 1'b0;
    too_cold_hold = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled right out of reset: held outputs are all zero
    write_setup(REG_ENABLE, 0);
    queue_tick(-40, 100, 0, 5000);
    queue_tick(150, 0, 0, 0);
    drain_results();

    // reset defaults: budget edges, boundaries, ethanol clamp
    apply_setup(10, 20, 60, 400, 120, 1, 1);
    queue_tick(150, 0, 0, 0);
    queue_tick(-40, 255, 0, 65535);
    queue_tick(-40, 100, 0, 65535);      // overshoots budget, seconds go to zero
    queue_tick(-40, 101, 0, 1);          // budget spent
    queue_tick(-40, 0, 65535, 0);        // running clears heater time
    queue_tick(-40, 0, 0, 60000);
    queue_tick(-40, 0, 0, 60000);        // lands exactly on the budget
    queue_tick(14, 50, 0, 1);
    queue_tick(15, 50, 0, 1);            // warm enough at the needed temperature
    queue_tick(-40, 99, 400, 0);         // running threshold
    queue_tick(-40, 99, 399, 999);
    queue_tick(59, 0, 0, 0);
    queue_tick(60, 0, 0, 0);
    queue_tick(-256, 0, 0, 0);
    queue_tick(255, 255, 65535, 65535);
    drain_results();

    // falling interpolation, truncation toward zero, seconds saturation
    apply_setup(100, -40, 150, 16000, 3600, 1, 1);
    queue_tick(-40, 33, 15999, 1000);
    queue_tick(53, 33, 0, 65535);
    queue_tick(54, 33, 0, 0);
    drain_results();

    // negative needed temperature and a zero budget
    apply_setup(-40, 100, -40, 16000, 0, 1, 1);
    queue_tick(-40, 0, 0, 100);
    queue_tick(-40, 10, 0, 100);
    queue_tick(-40, 100, 16000, 0);
    drain_results();

    // zero running rpm: always running
    apply_setup(10, 20, 60, 0, 1, 1, 1);
    queue_tick(-40, 50, 0, 500);
    drain_results();

    // heater removed mid-heat keeps its state, then resumes
    apply_setup(10, 20, 60, 400, 120, 1, 1);
    queue_tick(-40, 0, 0, 30000);
    drain_results();
    write_setup(REG_HEATER, 0);
    queue_tick(-40, 0, 0, 30000);
    drain_results();
    write_setup(REG_HEATER, 1);
    queue_tick(-40, 0, 0, 30000);
    drain_results();

    // disabled after activity: outputs hold
    write_setup(REG_ENABLE, 0);
    queue_tick(150, 0, 1000, 0);
    queue_tick(-40, 100, 0, 65535);
    drain_results();

    // random rounds, each with a mid-round drain
    for (round = 0; round < 9; round++) begin
      random_setup();
      idle_in = (round != 0) && ($urandom_range(3, 0) != 0);
      idle_out = (round != 0) && ($urandom_range(3, 0) != 0);
      n_round = set_enable ? 60 : 12;
      queue_random(n_round / 2);
      drain_results();
      queue_random(n_round - n_round / 2);
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) n_errors++;
    $display("%0d ticks over %0d register setups, %0d results checked", n_accepted,
             n_setups, n_results);
    $display("%0d results with heater on, %0d too cold to start", n_heating, n_too_cold);
    if (n_errors == 0) begin
      $display("PASS flex_fuel_cold_start_heater");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL flex_fuel_cold_start_heater");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("timeout, %0d results still outstanding", expected_results.size());
    $display("FAIL flex_fuel_cold_start_heater");
    $finish;
  end

endmodule

// ===== flex_fuel_cold_start_heater.f =====
+incdir+rtl
rtl/ffcs_pkg.sv
rtl/ffcs_if.sv
rtl/ffcs_cfg.sv
rtl/ffcs_front.sv
rtl/ffcs_ctrl.sv
rtl/ffcs_out.sv
rtl/flex_fuel_cold_start_heater.sv
verif/flex_fuel_cold_start_heater_test.sv
